>>> rtl/core/pty_channel_ring_buffers_top_assert.svh
// Assertion macros for the pseudo-terminal channel RTL.
`ifndef PTY_CHANNEL_RING_BUFFERS_TOP_ASSERT_SVH
`define PTY_CHANNEL_RING_BUFFERS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTY_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTY_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pty_crb_pkg.sv
// Types and codes for the pseudo-terminal channel ring buffers.
package pty_crb_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_RD
  } state_t;

  localparam logic [2:0] FN_OPEN  = 3'd0;
  localparam logic [2:0] FN_CLOSE = 3'd1;
  localparam logic [2:0] FN_WRITE = 3'd2;
  localparam logic [2:0] FN_READ  = 3'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_WBLOCK   = 3'd1;
  localparam logic [2:0] ST_EOF      = 3'd2;
  localparam logic [2:0] ST_PIPE     = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;
  localparam logic [2:0] ST_NOT_OPEN = 3'd5;

  localparam logic [7:0] NEWLINE = 8'h0A;

endpackage

>>> rtl/core/pty_crb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pty_crb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pty_channel_ring_buffers_top.sv
// Top level of the pseudo-terminal channel ring buffers.
// An item other than a read gives a single result after the pointer table lookup, held
// back while the output register is full. A read gives one byte per cycle while the output
// register is free. The next item is taken the cycle after the last result enters the
// output register. The pointer table read and the single ring read port set the pace.
// Reset clears the open flags, the state and the output valid; the memories are not swept,
// and no transfer is taken while reset is held.
`include "pty_channel_ring_buffers_top_assert.svh"
module pty_channel_ring_buffers_top
  import pty_crb_pkg::*;
#(
  parameter int NUM_CHANNELS = 16,
  parameter int BUFFER_BYTES = 512,
  parameter int MAX_READ     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[2:0], pty_index[6:3], side[7], data_byte[15:8], request_count[22:16]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], data_byte_out[10:3], line_end[11], readable[12], writable[13]
  output logic [15:0] out_tdata,
  // byte_valid[0]
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PW     = $clog2(BUFFER_BYTES);
  localparam int FW     = $clog2(BUFFER_BYTES + 1);
  localparam int SUM_W  = PW + 1;
  localparam int ENT_W  = 2 * (PW + FW);
  localparam int RING_W = CH_W + 1 + PW;

  state_t state_r, state_nxt;

  logic [2:0]      func_r;
  logic [CH_W-1:0] ch_r;
  logic            in_range_r;
  logic            side_r;
  logic [7:0]      byte_r;
  logic [6:0]      cnt_r;
  logic [PW-1:0]   cur_rp_r;
  logic [FW-1:0]   cur_free_r;
  logic [6:0]      left_r;
  logic [1:0]      side_open_r [NUM_CHANNELS];

  logic            out_valid_r;
  logic [2:0]      o_status_r;
  logic [7:0]      o_byte_r;
  logic            o_bv_r, o_last_r, o_le_r, o_rd_r, o_wr_r;

  logic [3:0]      pty_in;
  logic [CH_W+3:0] ch_wide;
  logic [CH_W-1:0] ch_in;
  logic            in_range_in;
  logic [6:0]      rc_in;

  logic             ptr_re, ptr_we;
  logic [ENT_W-1:0] ptr_rdata, ptr_wdata;
  logic             ring_re, ring_we;
  logic [RING_W-1:0] ring_raddr, ring_waddr;
  logic [7:0]       ring_rdata;

  logic [FW-1:0]    fr0, fr1, own_fr, peer_fr;
  logic [PW-1:0]    rp0, rp1, own_rp, peer_rp;
  logic             own_open, peer_open, out_free;
  logic [FW-1:0]    used;
  logic [SUM_W-1:0] wp_sum;
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rd_rp_nxt;
  logic [FW-1:0]    rd_free_nxt;
  logic             rd_nl, rd_stop;

  logic             emit, load_rd, step_rd, open_set, open_clr;
  logic [2:0]       e_status;
  logic [7:0]       e_byte;
  logic             e_bv, e_last, e_le, e_rd, e_wr;

  assign pty_in      = in_tdata[6:3];
  assign ch_wide     = {CH_W'(0), pty_in};
  assign ch_in       = ch_wide[CH_W-1:0];
  assign in_range_in = {3'b000, pty_in} < 7'(NUM_CHANNELS);
  assign rc_in       = (in_tdata[22:16] > 7'(MAX_READ)) ? 7'(MAX_READ) : in_tdata[22:16];

  assign fr0 = ptr_rdata[FW-1:0];
  assign rp0 = ptr_rdata[FW+PW-1:FW];
  assign fr1 = ptr_rdata[2*FW+PW-1:FW+PW];
  assign rp1 = ptr_rdata[ENT_W-1:2*FW+PW];

  assign own_fr  = side_r ? fr1 : fr0;
  assign own_rp  = side_r ? rp1 : rp0;
  assign peer_fr = side_r ? fr0 : fr1;
  assign peer_rp = side_r ? rp0 : rp1;

  assign own_open  = in_range_r && side_open_r[ch_r][side_r];
  assign peer_open = in_range_r && side_open_r[ch_r][~side_r];
  assign out_free  = !out_valid_r || out_tready;

  assign used   = FW'(BUFFER_BYTES) - peer_fr;
  assign wp_sum = SUM_W'(peer_rp) + SUM_W'(used);
  assign wp     = (wp_sum >= SUM_W'(BUFFER_BYTES)) ?
                  PW'(wp_sum - SUM_W'(BUFFER_BYTES)) : wp_sum[PW-1:0];

  assign rd_rp_nxt   = (cur_rp_r == PW'(BUFFER_BYTES - 1)) ? '0 : cur_rp_r + 1'b1;
  assign rd_free_nxt = cur_free_r + 1'b1;
  assign rd_nl       = !side_r && (ring_rdata == NEWLINE);
  assign rd_stop     = rd_nl || (left_r == 7'd1) || (rd_free_nxt == FW'(BUFFER_BYTES));

  assign ring_waddr = {ch_r, ~side_r, wp};

  pty_crb_ram #(
    .WIDTH(ENT_W),
    .DEPTH(2 ** CH_W)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ch_r),
    .wdata (ptr_wdata),
    .re    (ptr_re),
    .raddr (ch_in),
    .rdata (ptr_rdata)
  );

  pty_crb_ram #(
    .WIDTH(8),
    .DEPTH(2 ** RING_W)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (byte_r),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    ptr_re     = 1'b0;
    ptr_we     = 1'b0;
    ptr_wdata  = ptr_rdata;
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    ring_raddr = {ch_r, side_r, own_rp};
    emit       = 1'b0;
    load_rd    = 1'b0;
    step_rd    = 1'b0;
    open_set   = 1'b0;
    open_clr   = 1'b0;
    e_status   = ST_OK;
    e_byte     = 8'd0;
    e_bv       = 1'b0;
    e_last     = 1'b1;
    e_le       = 1'b0;
    e_rd       = 1'b0;
    e_wr       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid) begin
          ptr_re    = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (!in_range_r) begin
            e_status = ST_NOT_OPEN;
          end else begin
            case (func_r)
              FN_OPEN: begin
                if (own_open) begin
                  e_status = ST_BUSY;
                  e_rd     = own_fr < FW'(BUFFER_BYTES);
                  e_wr     = peer_fr != '0;
                end else begin
                  open_set = 1'b1;
                  if (!peer_open) begin
                    ptr_we    = 1'b1;
                    ptr_wdata = {PW'(0), FW'(BUFFER_BYTES), PW'(0), FW'(BUFFER_BYTES)};
                    e_wr      = 1'b1;
                  end else begin
                    e_rd = own_fr < FW'(BUFFER_BYTES);
                    e_wr = peer_fr != '0;
                  end
                end
              end
              FN_CLOSE: begin
                if (own_open) begin
                  open_clr = 1'b1;
                end else begin
                  e_status = ST_NOT_OPEN;
                end
              end
              FN_WRITE: begin
                if (!own_open) begin
                  e_status = ST_NOT_OPEN;
                end else begin
                  e_rd = own_fr < FW'(BUFFER_BYTES);
                  e_wr = peer_fr != '0;
                  if (peer_fr == '0) begin
                    e_status = ST_WBLOCK;
                  end else if (!peer_open) begin
                    e_status = ST_PIPE;
                  end else begin
                    ring_we = 1'b1;
                    ptr_we  = 1'b1;
                    e_wr    = (peer_fr - 1'b1) != '0;
                    if (side_r) begin
                      ptr_wdata = {rp1, fr1, rp0, fr0 - 1'b1};
                    end else begin
                      ptr_wdata = {rp1, fr1 - 1'b1, rp0, fr0};
                    end
                  end
                end
              end
              FN_READ: begin
                if (!own_open) begin
                  e_status = ST_NOT_OPEN;
                end else if (own_fr >= FW'(BUFFER_BYTES)) begin
                  e_status = peer_open ? ST_WBLOCK : ST_EOF;
                  e_wr     = peer_fr != '0;
                end else if (cnt_r == 7'd0) begin
                  e_rd = 1'b1;
                  e_wr = peer_fr != '0;
                end else begin
                  emit      = 1'b0;
                  load_rd   = 1'b1;
                  ring_re   = 1'b1;
                  state_nxt = S_RD;
                end
              end
              default: begin
                if (own_open) begin
                  e_rd = own_fr < FW'(BUFFER_BYTES);
                  e_wr = peer_fr != '0;
                end else begin
                  e_status = ST_NOT_OPEN;
                end
              end
            endcase
          end
        end
      end
      S_RD: begin
        ring_raddr = {ch_r, side_r, rd_rp_nxt};
        if (out_free) begin
          emit    = 1'b1;
          step_rd = 1'b1;
          e_byte  = ring_rdata;
          e_bv    = 1'b1;
          e_last  = rd_stop;
          e_le    = rd_nl;
          e_rd    = rd_free_nxt < FW'(BUFFER_BYTES);
          e_wr    = peer_fr != '0;
          if (rd_stop) begin
            ptr_we    = 1'b1;
            state_nxt = S_IDLE;
            if (side_r) begin
              ptr_wdata = {rd_rp_nxt, rd_free_nxt, rp0, fr0};
            end else begin
              ptr_wdata = {rp1, fr1, rd_rp_nxt, rd_free_nxt};
            end
          end else begin
            ring_re = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r     <= in_tdata[2:0];
      ch_r       <= ch_in;
      in_range_r <= in_range_in;
      side_r     <= in_tdata[7];
      byte_r     <= in_tdata[15:8];
      cnt_r      <= rc_in;
    end
    if (load_rd) begin
      cur_rp_r   <= own_rp;
      cur_free_r <= own_fr;
      left_r     <= cnt_r;
    end else if (step_rd) begin
      cur_rp_r   <= rd_rp_nxt;
      cur_free_r <= rd_free_nxt;
      left_r     <= left_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        side_open_r[i] <= 2'b00;
      end
    end else if (open_set) begin
      side_open_r[ch_r][side_r] <= 1'b1;
    end else if (open_clr) begin
      side_open_r[ch_r][side_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_status_r <= e_status;
      o_byte_r   <= e_byte;
      o_bv_r     <= e_bv;
      o_last_r   <= e_last;
      o_le_r     <= e_le;
      o_rd_r     <= e_rd;
      o_wr_r     <= e_wr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_wr_r, o_rd_r, o_le_r, o_byte_r, o_status_r};
  assign out_tuser  = o_bv_r;
  assign out_tlast  = o_last_r;

  `PTY_ASSERT_NXT(a_accept_to_look, in_tvalid && in_tready, state_r == S_LOOK,
    "Transfer in did not lead to the pointer lookup")
  `PTY_ASSERT_NOW(a_byte_status_ok, out_tvalid && out_tuser, out_tdata[2:0] == ST_OK,
    "Popped byte carries a status other than ok")
  `PTY_ASSERT_NOW(a_line_end_last, out_tvalid && out_tdata[11], out_tuser && out_tlast,
    "Line end without a final popped byte")
  `PTY_ASSERT_NOW(a_rd_not_empty, state_r == S_RD,
    (cur_free_r < FW'(BUFFER_BYTES)) && (left_r != 7'd0),
    "Read walk on an empty buffer or with no bytes left")

endmodule

>>> verif/pty_channel_ring_buffers_top_tb.sv
// Self-checking testbench for the pseudo-terminal channel ring buffers, with a scoreboard model.
module pty_channel_ring_buffers_top_tb;
  import pty_crb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_CHANNELS  = 16;
  localparam int TB_BUF_BYTES = 512;
  localparam int TB_MAX_READ  = 64;
  localparam int TB_FIFOS     = TB_CHANNELS * 2;
  localparam int RANDOM_ITEMS = 290;
  localparam int QUIET_ITEMS  = 60;
  localparam int HOLD_ITEM    = 150;
  localparam int CYCLE_LIMIT  = 4000000;

  localparam logic [2:0] FN_POLL     = 3'd4;
  localparam logic [2:0] FN_UNUSED_5 = 3'd5;
  localparam logic [2:0] FN_UNUSED_7 = 3'd7;

  localparam logic SIDE_SLAVE  = 1'b0;
  localparam logic SIDE_MASTER = 1'b1;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] idx;
    logic       side;
    logic [7:0] data;
    logic [6:0] count;
  } pty_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
    logic       line_end;
    logic       readable;
    logic       writable;
  } pty_result_t;

  typedef struct {
    pty_item_t  item;
    bit         typed;
    logic [2:0] status;
    logic       readable;
    logic       writable;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic [7:0]  ring_mem [TB_FIFOS][TB_BUF_BYTES];
  int unsigned rd_ptr [TB_FIFOS];
  int unsigned free_cnt [TB_FIFOS];
  bit          side_is_open [TB_FIFOS];

  pty_result_t pty_result_q[$];
  dir_row_t    dir_rows[$];
  pty_result_t got_result;
  pty_result_t want_result;
  bit          quiet_phase = 1'b0;
  int          err_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          cycle_count = 0;

  pty_channel_ring_buffers_top #(
    .NUM_CHANNELS(TB_CHANNELS),
    .BUFFER_BYTES(TB_BUF_BYTES),
    .MAX_READ    (TB_MAX_READ)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic pty_item_t mk_item(logic [2:0] func, logic [3:0] idx, logic side,
                                        logic [7:0] data, logic [6:0] count);
    pty_item_t it;
    it.func  = func;
    it.idx   = idx;
    it.side  = side;
    it.data  = data;
    it.count = count;
    return it;
  endfunction

  function automatic dir_row_t dir_row(pty_item_t it, bit typed, logic [2:0] st,
                                       logic rd, logic wr);
    dir_row_t r;
    r.item     = it;
    r.typed    = typed;
    r.status   = st;
    r.readable = rd;
    r.writable = wr;
    return r;
  endfunction

  task automatic add_result(int own, int peer, logic [2:0] st, logic [7:0] d, logic bv,
                            logic last, logic le);
    pty_result_t r;
    r.status     = st;
    r.data       = d;
    r.byte_valid = bv;
    r.last       = last;
    r.line_end   = le;
    r.readable   = side_is_open[own] && (free_cnt[own] < TB_BUF_BYTES);
    r.writable   = side_is_open[own] && (free_cnt[peer] > 0);
    pty_result_q.push_back(r);
  endtask

  task automatic compute_pty_results(pty_item_t it);
    int own;
    int peer;
    int n;
    int wp;
    logic [7:0] b;
    bit nl;
    bit stop;
    if (int'(it.idx) >= TB_CHANNELS) begin
      pty_result_q.push_back(pty_result_t'{ST_NOT_OPEN, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
      return;
    end
    own  = int'(it.idx) * 2 + int'(it.side);
    peer = int'(it.idx) * 2 + 1 - int'(it.side);
    if (it.func == FN_OPEN) begin
      if (side_is_open[own]) begin
        add_result(own, peer, ST_BUSY, 8'h00, 1'b0, 1'b1, 1'b0);
      end else begin
        if (!side_is_open[peer]) begin
          rd_ptr[own]    = 0;
          free_cnt[own]  = TB_BUF_BYTES;
          rd_ptr[peer]   = 0;
          free_cnt[peer] = TB_BUF_BYTES;
        end
        side_is_open[own] = 1'b1;
        add_result(own, peer, ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
      end
    end else if (it.func <= FN_READ && !side_is_open[own]) begin
      add_result(own, peer, ST_NOT_OPEN, 8'h00, 1'b0, 1'b1, 1'b0);
    end else if (it.func == FN_CLOSE) begin
      side_is_open[own] = 1'b0;
      add_result(own, peer, ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
    end else if (it.func == FN_WRITE) begin
      if (free_cnt[peer] == 0) begin
        add_result(own, peer, ST_WBLOCK, 8'h00, 1'b0, 1'b1, 1'b0);
      end else if (!side_is_open[peer]) begin
        add_result(own, peer, ST_PIPE, 8'h00, 1'b0, 1'b1, 1'b0);
      end else begin
        wp = (rd_ptr[peer] + TB_BUF_BYTES - free_cnt[peer]) % TB_BUF_BYTES;
        ring_mem[peer][wp] = it.data;
        free_cnt[peer] = free_cnt[peer] - 1;
        add_result(own, peer, ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
      end
    end else if (it.func == FN_READ) begin
      n = (int'(it.count) > TB_MAX_READ) ? TB_MAX_READ : int'(it.count);
      if (free_cnt[own] >= TB_BUF_BYTES) begin
        add_result(own, peer, side_is_open[peer] ? ST_WBLOCK : ST_EOF, 8'h00, 1'b0, 1'b1,
                   1'b0);
      end else if (n == 0) begin
        add_result(own, peer, ST_OK, 8'h00, 1'b0, 1'b1, 1'b0);
      end else begin
        for (int k = 0; k < n; k++) begin
          b = ring_mem[own][rd_ptr[own]];
          rd_ptr[own]   = (rd_ptr[own] + 1) % TB_BUF_BYTES;
          free_cnt[own] = free_cnt[own] + 1;
          nl   = (it.side == SIDE_SLAVE) && (b == NEWLINE);
          stop = nl || (k + 1 == n) || (free_cnt[own] >= TB_BUF_BYTES);
          add_result(own, peer, ST_OK, b, 1'b1, stop, nl);
          if (stop) break;
        end
      end
    end else begin
      add_result(own, peer, side_is_open[own] ? ST_OK : ST_NOT_OPEN, 8'h00, 1'b0, 1'b1,
                 1'b0);
    end
  endtask

  task automatic send_pty_item(pty_item_t it);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, it.count, it.data, it.side, it.idx, it.func};
    do @(posedge clk); while (!in_tready);
    compute_pty_results(it);
    sent_count++;
  endtask

  task automatic maybe_gap();
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic pty_item_t random_pty_item();
    pty_item_t it;
    int pick;
    int cnt_pick;
    pick     = $urandom_range(0, 99);
    cnt_pick = $urandom_range(0, 19);
    it.idx   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    it.side  = 1'($urandom_range(0, 1));
    it.data  = ($urandom_range(0, 4) == 0) ? NEWLINE : 8'($urandom);
    if (cnt_pick == 0) it.count = 7'd0;
    else if (cnt_pick == 1) it.count = 7'($urandom_range(TB_MAX_READ + 1, 127));
    else it.count = 7'($urandom_range(1, TB_MAX_READ));
    if (pick < 10) it.func = FN_OPEN;
    else if (pick < 15) it.func = FN_CLOSE;
    else if (pick < 55) it.func = FN_WRITE;
    else if (pick < 80) it.func = FN_READ;
    else if (pick < 92) it.func = FN_POLL;
    else it.func = 3'($urandom_range(int'(FN_UNUSED_5), int'(FN_UNUSED_7)));
    return it;
  endfunction

  task automatic note_failure(string what, pty_result_t want, pty_result_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%s at cycle %0d: exp st=%0d d=%02h bv=%0b last=%0b le=%0b rd=%0b wr=%0b",
               what, cycle_count, want.status, want.data, want.byte_valid, want.last,
               want.line_end, want.readable, want.writable);
      $display("  got st=%0d d=%02h bv=%0b last=%0b le=%0b rd=%0b wr=%0b",
               got.status, got.data, got.byte_valid, got.last, got.line_end, got.readable,
               got.writable);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result.status     = out_tdata[2:0];
      got_result.data       = out_tdata[10:3];
      got_result.line_end   = out_tdata[11];
      got_result.readable   = out_tdata[12];
      got_result.writable   = out_tdata[13];
      got_result.byte_valid = out_tuser;
      got_result.last       = out_tlast;
      checked_count++;
      if (pty_result_q.size() == 0) begin
        note_failure("Unexpected result", '0, got_result);
      end else begin
        want_result = pty_result_q.pop_front();
        if (got_result !== want_result) note_failure("Mismatch", want_result, got_result);
      end
    end
  end

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    pty_item_t it;
    int fill_fifo;
    dir_rows.push_back(dir_row(mk_item(FN_POLL, 4'd0, SIDE_SLAVE, 8'h00, 7'd1), 1'b1,
                               ST_NOT_OPEN, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(mk_item(FN_WRITE, 4'd0, SIDE_SLAVE, 8'hFF, 7'd1), 1'b1,
                               ST_NOT_OPEN, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(mk_item(FN_READ, 4'd0, SIDE_MASTER, 8'h00, 7'd1), 1'b1,
                               ST_NOT_OPEN, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(mk_item(FN_CLOSE, 4'd0, SIDE_SLAVE, 8'h00, 7'd1), 1'b1,
                               ST_NOT_OPEN, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(mk_item(FN_OPEN, 4'd0, SIDE_SLAVE, 8'h00, 7'd1), 1'b1,
                               ST_OK, 1'b0, 1'b1));
    dir_rows.push_back(dir_row(mk_item(FN_OPEN, 4'd0, SIDE_SLAVE, 8'h00, 7'd1), 1'b1,
                               ST_BUSY, 1'b0, 1'b1));
    dir_rows.push_back(dir_row(mk_item(FN_WRITE, 4'd0, SIDE_SLAVE, 8'hFF, 7'd1), 1'b1,
                               ST_PIPE, 1'b0, 1'b1));
    dir_rows.push_back(dir_row(mk_item(FN_READ, 4'd0, SIDE_SLAVE, 8'h00, 7'd64), 1'b1,
                               ST_EOF, 1'b0, 1'b1));
    dir_rows.push_back(dir_row(mk_item(FN_OPEN, 4'd0, SIDE_MASTER, 8'h00, 7'd1), 1'b1,
                               ST_OK, 1'b0, 1'b1));
    dir_rows.push_back(dir_row(mk_item(FN_READ, 4'd0, SIDE_MASTER, 8'h00, 7'd64), 1'b1,
                               ST_WBLOCK, 1'b0, 1'b1));
    dir_rows.push_back(dir_row(mk_item(FN_WRITE, 4'd0, SIDE_MASTER, 8'h41, 7'd1), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_WRITE, 4'd0, SIDE_MASTER, NEWLINE, 7'd1), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_WRITE, 4'd0, SIDE_MASTER, 8'h00, 7'd1), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_WRITE, 4'd0, SIDE_MASTER, 8'hFF, 7'd1), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_READ, 4'd0, SIDE_SLAVE, 8'h00, 7'd127), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_READ, 4'd0, SIDE_SLAVE, 8'h00, 7'd0), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_READ, 4'd0, SIDE_SLAVE, 8'h00, 7'd127), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_WRITE, 4'd0, SIDE_SLAVE, NEWLINE, 7'd1), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_READ, 4'd0, SIDE_MASTER, 8'h00, 7'd1), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_POLL, 4'd0, SIDE_MASTER, 8'h00, 7'd1), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_UNUSED_5, 4'd15, SIDE_MASTER, 8'h00, 7'd1), 1'b1,
                               ST_NOT_OPEN, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(mk_item(FN_UNUSED_7, 4'd9, SIDE_SLAVE, 8'h00, 7'd1), 1'b1,
                               ST_NOT_OPEN, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(mk_item(FN_CLOSE, 4'd0, SIDE_MASTER, 8'h00, 7'd1), 1'b1,
                               ST_OK, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(mk_item(FN_WRITE, 4'd0, SIDE_SLAVE, 8'h55, 7'd1), 1'b1,
                               ST_PIPE, 1'b0, 1'b1));
    dir_rows.push_back(dir_row(mk_item(FN_OPEN, 4'd15, SIDE_MASTER, 8'hFF, 7'd127), 0, 0, 0, 0));
    dir_rows.push_back(dir_row(mk_item(FN_CLOSE, 4'd0, SIDE_SLAVE, 8'h00, 7'd1), 1'b1,
                               ST_OK, 1'b0, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      maybe_gap();
      send_pty_item(dir_rows[i].item);
      if (dir_rows[i].typed) begin
        void'(pty_result_q.pop_back());
        pty_result_q.push_back(pty_result_t'{dir_rows[i].status, 8'h00, 1'b0, 1'b1, 1'b0,
                                             dir_rows[i].readable, dir_rows[i].writable});
      end
    end

    // Stream a run of bytes through one pair and drain it, then reopen its slave end.
    fill_fifo = 3 * 2;
    send_pty_item(mk_item(FN_OPEN, 4'd3, SIDE_SLAVE, 8'h00, 7'd1));
    send_pty_item(mk_item(FN_OPEN, 4'd3, SIDE_MASTER, 8'h00, 7'd1));
    repeat (40) begin
      maybe_gap();
      send_pty_item(mk_item(FN_WRITE, 4'd3, SIDE_MASTER, 8'($urandom), 7'd1));
    end
    while (free_cnt[fill_fifo] < TB_BUF_BYTES) begin
      maybe_gap();
      send_pty_item(mk_item(FN_READ, 4'd3, SIDE_SLAVE, 8'h00, 7'd64));
    end
    send_pty_item(mk_item(FN_CLOSE, 4'd3, SIDE_SLAVE, 8'h00, 7'd1));
    send_pty_item(mk_item(FN_WRITE, 4'd3, SIDE_MASTER, 8'h33, 7'd1));
    send_pty_item(mk_item(FN_OPEN, 4'd3, SIDE_SLAVE, 8'h00, 7'd1));
    send_pty_item(mk_item(FN_POLL, 4'd3, SIDE_SLAVE, 8'h00, 7'd1));
    send_pty_item(mk_item(FN_READ, 4'd3, SIDE_SLAVE, 8'h00, 7'd64));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
      if (i == HOLD_ITEM) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pty_result_q.size() != 0);
      end
      maybe_gap();
      it = random_pty_item();
      send_pty_item(it);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pty_result_q.size() != 0);
    repeat (8) @(posedge clk);

    $display("Summary: %0d items sent, %0d results checked, %0d failures.",
             sent_count, checked_count, err_count);
    $display("Covered opens, closes, pipe writes, line-mode, empty and long reads.");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> pty_channel_ring_buffers_top.f
+incdir+rtl/core
rtl/core/pty_crb_pkg.sv
rtl/core/pty_crb_ram.sv
rtl/core/pty_channel_ring_buffers_top.sv
verif/pty_channel_ring_buffers_top_tb.sv
